// ===== hw/rtl/assembler_token_scanner_top_defines.svh =====
// Assertion macros for the assembler token scanner.
`ifndef ASSEMBLER_TOKEN_SCANNER_TOP_DEFINES_SVH
`define ASSEMBLER_TOKEN_SCANNER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// ante holds in this cycle -> cons holds in the same cycle
`define ATS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ats assertion failed");

// ante holds in this cycle -> cons holds in the next cycle
`define ATS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ats assertion failed");

`else

`define ATS_ASSERT_NOW(lbl, ante, cons)
`define ATS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== hw/rtl/ats_pkg.sv =====
// Types, constants and character tests shared by the token scanner modules.
package ats_pkg;

    localparam int CH_W  = 8;
    localparam int CLS_W = 3;
    localparam int LEN_W = 5;
    localparam int REC_N = 3;

    localparam logic [1:0] MODE_IDLE   = 2'd0;
    localparam logic [1:0] MODE_WORD   = 2'd1;
    localparam logic [1:0] MODE_SIGNED = 2'd2;

    localparam logic [1:0] WC_ALPHA = 2'd0;
    localparam logic [1:0] WC_NUM   = 2'd1;
    localparam logic [1:0] WC_MIXED = 2'd2;

    localparam logic [CLS_W-1:0] CLS_ALPHA = 3'd0;
    localparam logic [CLS_W-1:0] CLS_NUM   = 3'd1;
    localparam logic [CLS_W-1:0] CLS_MIXED = 3'd2;
    localparam logic [CLS_W-1:0] CLS_OP    = 3'd3;
    localparam logic [CLS_W-1:0] CLS_BAD   = 3'd4;
    localparam logic [CLS_W-1:0] CLS_END   = 3'd5;

    localparam logic REC_CHAR = 1'b0;
    localparam logic REC_DONE = 1'b1;

    localparam logic [CH_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_W-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_W-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_Z   = 8'h5A;
    localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_Z   = 8'h7A;

    typedef struct packed {
        logic             kind;
        logic [CH_W-1:0]  ch;
        logic [CLS_W-1:0] cls;
        logic [LEN_W-1:0] len;
    } rec_t;

    // all records caused by one input byte
    typedef struct packed {
        logic [1:0]           cnt;
        rec_t [REC_N-1:0]     rec;
    } bundle_t;

    function automatic logic is_letter(input logic [CH_W-1:0] c);
        is_letter = (c >= CH_LC_A && c <= CH_LC_Z) || (c >= CH_UC_A && c <= CH_UC_Z);
    endfunction

    function automatic logic is_digit(input logic [CH_W-1:0] c);
        is_digit = c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [CH_W-1:0] c);
        is_space = c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_op(input logic [CH_W-1:0] c);
        is_op = c == CH_COMMA || c == CH_LPAREN || c == CH_RPAREN ||
                c == CH_COLON || c == CH_STAR;
    endfunction

endpackage

// ===== hw/rtl/ats_scanner.sv =====
// Scan state and per-byte record generation.
module ats_scanner #(
    parameter int LEXEME_CAP = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [7:0]             char_value,
    input  logic                   end_of_input,
    output ats_pkg::bundle_t       bundle,
    output logic                   push
);
    import ats_pkg::*;

    localparam int CNT_W = $clog2(LEXEME_CAP + 1);
    localparam logic [CNT_W-1:0] CAP = CNT_W'(LEXEME_CAP);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);

    logic [1:0]       mode_reg, mode_next;
    logic [1:0]       class_reg, class_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic letter, digit, space, sign, open;
    rec_t close_rec, end_rec, char_rec, single_rec;
    logic [1:0] start_n;

    always_comb
    begin
        letter = is_letter(char_value);
        digit  = is_digit(char_value);
        space  = is_space(char_value);
        sign   = char_value == CH_PLUS || char_value == CH_MINUS;
        open   = mode_reg != MODE_IDLE;

        close_rec.kind = REC_DONE;
        close_rec.ch   = '0;
        close_rec.cls  = (mode_reg == MODE_WORD) ? {1'b0, class_reg} : CLS_NUM;
        close_rec.len  = LEN_W'(count_reg);

        end_rec.kind = REC_DONE;
        end_rec.ch   = '0;
        end_rec.cls  = CLS_END;
        end_rec.len  = '0;

        char_rec.kind = REC_CHAR;
        char_rec.ch   = char_value;
        char_rec.cls  = '0;
        char_rec.len  = '0;

        single_rec.kind = REC_DONE;
        single_rec.ch   = '0;
        single_rec.cls  = is_op(char_value) ? CLS_OP : CLS_BAD;
        single_rec.len  = LEN_W'(1);

        if (space)
            start_n = 2'd0;
        else if (letter || digit || sign)
            start_n = 2'd1;
        else
            start_n = 2'd2;

        mode_next  = mode_reg;
        class_next = class_reg;
        count_next = count_reg;
        bundle     = '0;

        priority if (end_of_input)
        begin
            if (open)
            begin
                bundle.rec[0] = close_rec;
                bundle.rec[1] = end_rec;
                bundle.cnt    = 2'd2;
            end
            else
            begin
                bundle.rec[0] = end_rec;
                bundle.cnt    = 2'd1;
            end
            mode_next  = MODE_IDLE;
            class_next = WC_ALPHA;
            count_next = '0;
        end
        else if (char_value == CH_NUL)
        begin
            bundle.cnt = 2'd0;
        end
        else if (mode_reg == MODE_WORD && (letter || digit))
        begin
            if (count_reg < CAP)
            begin
                count_next = count_reg + ONE;
                if (letter && class_reg == WC_NUM)
                    class_next = WC_MIXED;
                else if (digit && class_reg == WC_ALPHA)
                    class_next = WC_MIXED;
                bundle.rec[0] = char_rec;
                bundle.cnt    = 2'd1;
            end
        end
        else if (mode_reg == MODE_SIGNED && digit)
        begin
            if (count_reg < CAP)
            begin
                count_next    = count_reg + ONE;
                bundle.rec[0] = char_rec;
                bundle.cnt    = 2'd1;
            end
        end
        else
        begin
            // close any open token, then start a new one with this byte unless it is white space
            mode_next  = MODE_IDLE;
            class_next = WC_ALPHA;
            count_next = '0;
            if (letter || digit)
            begin
                mode_next  = MODE_WORD;
                class_next = letter ? WC_ALPHA : WC_NUM;
                count_next = ONE;
            end
            else if (sign)
            begin
                mode_next  = MODE_SIGNED;
                class_next = WC_NUM;
                count_next = ONE;
            end
            if (open)
            begin
                bundle.rec[0] = close_rec;
                bundle.rec[1] = char_rec;
                bundle.rec[2] = single_rec;
                bundle.cnt    = 2'd1 + start_n;
            end
            else
            begin
                bundle.rec[0] = char_rec;
                bundle.rec[1] = single_rec;
                bundle.cnt    = start_n;
            end
        end

        push = accept && bundle.cnt != 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            class_reg <= WC_ALPHA;
            count_reg <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            class_reg <= class_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== hw/rtl/ats_emitter.sv =====
// Two-entry record-group queue and one-record-per-beat output.
module ats_emitter (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ats_pkg::bundle_t       bundle,
    output logic                   full,
    output logic                   rec_valid,
    input  logic                   rec_stall,
    output ats_pkg::rec_t          rec,
    output logic                   last
);
    import ats_pkg::*;

    bundle_t    q_reg [2];
    logic       wr_reg, rd_reg;
    logic [1:0] fill_reg, fill_next;
    logic [1:0] idx_reg, idx_next;

    bundle_t head;
    logic    beat, pop;

    always_comb
    begin
        head      = q_reg[rd_reg];
        rec_valid = fill_reg != 2'd0;
        full      = fill_reg == 2'd2;
        unique case (idx_reg)
            2'd0:    rec = head.rec[0];
            2'd1:    rec = head.rec[1];
            2'd2:    rec = head.rec[2];
            default: rec = head.rec[0];
        endcase
        last = idx_reg == head.cnt - 2'd1;
        beat = rec_valid && !rec_stall;
        pop  = beat && last;

        unique case ({push, pop})
            2'b10:   fill_next = fill_reg + 2'd1;
            2'b01:   fill_next = fill_reg - 2'd1;
            default: fill_next = fill_reg;
        endcase

        if (pop)
            idx_next = 2'd0;
        else if (beat)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_reg] <= bundle;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg   <= 1'b0;
            rd_reg   <= 1'b0;
            fill_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
        end
    end

endmodule

// ===== hw/rtl/assembler_token_scanner_top.sv =====
// Assembler token scanner top level: one source byte per beat in, one record per beat out.
// Accepts one byte per cycle while char_stall is low. Each byte yields zero to three records,
// which are registered into a queue and sent from it one per cycle while rec_stall is low.
// Scan state updates in the cycle a byte is taken, and the records of up to two bytes wait
// in a queue ahead of the output; the input stalls while it is full.
`include "assembler_token_scanner_top_defines.svh"

module assembler_token_scanner_top #(
    parameter int LEXEME_CAP = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       char_valid,
    output logic       char_stall,
    input  logic [7:0] char_value,
    input  logic       end_of_input,
    output logic       rec_valid,
    input  logic       rec_stall,
    output logic       record_kind,
    output logic [7:0] lexeme_char,
    output logic [2:0] token_class,
    output logic [4:0] token_length,
    output logic       last
);
    import ats_pkg::*;

    logic    accept, push, full;
    bundle_t bundle;
    rec_t    rec;

    assign char_stall = full;
    assign accept     = char_valid && !full;

    ats_scanner #(
        .LEXEME_CAP(LEXEME_CAP)
    ) u_scanner (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .char_value  (char_value),
        .end_of_input(end_of_input),
        .bundle      (bundle),
        .push        (push)
    );

    ats_emitter u_emitter (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .bundle   (bundle),
        .full     (full),
        .rec_valid(rec_valid),
        .rec_stall(rec_stall),
        .rec      (rec),
        .last     (last)
    );

    assign record_kind  = rec.kind;
    assign lexeme_char  = rec.ch;
    assign token_class  = rec.cls;
    assign token_length = rec.len;

    `ATS_ASSERT_NOW(a_stall_has_rec, char_stall, rec_valid)
    `ATS_ASSERT_NEXT(a_eoi_gives_rec, char_valid && !char_stall && end_of_input, rec_valid)
    `ATS_ASSERT_NEXT(a_group_continues, rec_valid && !rec_stall && !last, rec_valid)
    `ATS_ASSERT_NOW(a_end_is_last, rec_valid && record_kind == REC_DONE && token_class == CLS_END, last)

endmodule
